// ----- rtl/cidr_allow_list_match_top_defines.svh -----
// Assertion macros shared by the allow list match block
`ifndef CIDR_ALLOW_LIST_MATCH_TOP_DEFINES_SVH
`define CIDR_ALLOW_LIST_MATCH_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define CIDRAL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define CIDRAL_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/cidral_pkg.sv -----
// Shared types, sizes and codes of the allow list match block
package cidral_pkg;

	// Table size and derived widths
	localparam int MAX_ENTRIES = 16;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// How the result of the current item is formed
	localparam logic [1:0] RES_NONE  = 2'd0;
	localparam logic [1:0] RES_FULL  = 2'd1;
	localparam logic [1:0] RES_ALLOW = 2'd2;
	localparam logic [1:0] RES_SCAN  = 2'd3;

	// Input transfer payload
	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic        addr_is_v4;
		logic [7:0]  prefix_len;
	} cidral_req_t;

	// Output transfer payload
	typedef struct packed {
		logic allowed;
		logic status;
	} cidral_rsp_t;

	// One stored table entry
	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix;
	} cidral_entry_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       latch;
		logic       wr_en;
		logic       cnt_clr;
		logic       scan_start;
		logic       rd_en;
		logic       out_load;
		logic [1:0] res_kind;
	} cidral_dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic last;
	} cidral_dp_sts_t;

endpackage

// ----- rtl/cidral_ram.sv -----
// Generic single write port RAM with registered read
module cidral_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cidral_ctrl.sv -----
// Controller state machine of the allow list match block
module cidral_ctrl
	import cidral_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic [1:0]     command,
	output logic           cmd_stall,
	output logic           res_valid,
	input  logic           res_stall,
	output cidral_dp_cmd_t dp_cmd,
	input  cidral_dp_sts_t dp_sts
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [1:0] kind_q;
	logic [1:0] kind_d;
	logic       res_valid_q;
	logic       out_free;

	// Output register can take a result when empty or being drained
	assign out_free = !res_valid_q || !res_stall;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		dp_cmd = '0;
		dp_cmd.res_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.latch = 1'b1;
					state_d = S_FIN;
					kind_d = RES_NONE;
					unique case (command)
						CMD_INSERT: begin
							if (dp_sts.full) begin
								kind_d = RES_FULL;
							end else begin
								dp_cmd.wr_en = 1'b1;
							end
						end
						CMD_LOOKUP: begin
							if (dp_sts.empty) begin
								kind_d = RES_ALLOW;
							end else begin
								kind_d = RES_SCAN;
								dp_cmd.scan_start = 1'b1;
								state_d = S_SCAN;
							end
						end
						CMD_CLEAR: begin
							dp_cmd.cnt_clr = 1'b1;
						end
						default: begin
							kind_d = RES_NONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				dp_cmd.rd_en = 1'b1;
				if (dp_sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last entry is compared in this cycle
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					dp_cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= RES_NONE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			if (dp_cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

endmodule

// ----- rtl/cidral_dp.sv -----
// Datapath: address mapping, entry table, prefix compare and result register
module cidral_dp
	import cidral_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  cidral_req_t    cmd,
	input  cidral_dp_cmd_t dp_cmd,
	output cidral_dp_sts_t dp_sts,
	output cidral_rsp_t    res
);

	localparam logic [8:0]   V4_PREFIX_OFFSET = 9'd96;
	localparam logic [7:0]   FULL_PREFIX = 8'd128;
	localparam logic [31:0]  V4_MAP_MARK = 32'h0000_ffff;
	localparam logic [127:0] ALL_ONES = '1;

	// Mask with the top p bits set, p up to 128
	function automatic logic [127:0] top_mask(input logic [7:0] p);
		logic [127:0] m;
		if (p >= FULL_PREFIX) begin
			m = ALL_ONES;
		end else begin
			m = ~(ALL_ONES >> p);
		end
		return m;
	endfunction

	logic [63:0]     map_hi;
	logic [63:0]     map_lo;
	logic [8:0]      plen_sum;
	logic [7:0]      plen_sat;
	cidral_entry_t   wr_entry;
	cidral_entry_t   rd_entry;
	logic [127:0]    key_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic            cmp_vld_q;
	logic            hit_q;
	logic            match;
	cidral_rsp_t     res_q;

	// IPv4 goes to ::ffff:a.b.c.d
	assign map_hi = cmd.addr_is_v4 ? 64'd0 : cmd.addr_high;
	assign map_lo = cmd.addr_is_v4 ? {V4_MAP_MARK, cmd.addr_low[31:0]} : cmd.addr_low;

	// Stored prefix, IPv4 offset added, saturated at full length
	assign plen_sum = {1'b0, cmd.prefix_len} + (cmd.addr_is_v4 ? V4_PREFIX_OFFSET : 9'd0);
	assign plen_sat = (plen_sum > {1'b0, FULL_PREFIX}) ? FULL_PREFIX : plen_sum[7:0];

	assign wr_entry.addr_high = map_hi;
	assign wr_entry.addr_low = map_lo;
	assign wr_entry.prefix = plen_sat;

	// Entry table
	cidral_ram #(
		.WIDTH($bits(cidral_entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (dp_cmd.wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(wr_entry),
		.re   (dp_cmd.rd_en),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	// Lookup key
	always_ff @(posedge clk) begin
		if (dp_cmd.latch) begin
			key_q <= {map_hi, map_lo};
		end
	end

	// Masked compare of the entry read last cycle
	assign match = (((key_q ^ {rd_entry.addr_high, rd_entry.addr_low})
		& top_mask(rd_entry.prefix)) == 128'd0);

	// Fill count, scan index and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			cmp_vld_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (dp_cmd.cnt_clr) begin
				count_q <= '0;
			end else if (dp_cmd.wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (dp_cmd.scan_start) begin
				idx_q <= '0;
			end else if (dp_cmd.rd_en) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			cmp_vld_q <= dp_cmd.rd_en;
			if (dp_cmd.scan_start) begin
				hit_q <= 1'b0;
			end else if (cmp_vld_q && match) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			res_q.allowed <= (dp_cmd.res_kind == RES_ALLOW)
				|| ((dp_cmd.res_kind == RES_SCAN) && hit_q);
			res_q.status <= (dp_cmd.res_kind == RES_FULL);
		end
	end

	assign dp_sts.full = (count_q == CNT_W'(MAX_ENTRIES));
	assign dp_sts.empty = (count_q == '0);
	assign dp_sts.last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign res = res_q;

endmodule

// ----- rtl/cidr_allow_list_match_top.sv -----
// Top level of the IP prefix allow list match block
// Holds up to MAX_ENTRIES allowed prefixes (128-bit address plus length, IPv4 mapped
// to ::ffff:a.b.c.d with 96 added to its length, saturating at 128). Each input transfer
// carries one command and gives exactly one result transfer: insert returns status 1 when
// the table is full, lookup returns allowed 1 when the table is empty or any entry matches
// on its leading prefix bits, clear empties the table. Items are handled one at a time:
// insert, clear, unused codes and a lookup on an empty table need no scan; a lookup on a
// non-empty table reads the table RAM one entry per cycle and compares each entry in the
// cycle after its read. The result sits in an output register, so the next item is
// accepted while a finished result waits to be taken.
`include "cidr_allow_list_match_top_defines.svh"

module cidr_allow_list_match_top
	import cidral_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cidral_req_t cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output cidral_rsp_t res
);

	cidral_dp_cmd_t dp_cmd;
	cidral_dp_sts_t dp_sts;

	// Sequencing
	cidral_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.command  (cmd.command),
		.cmd_stall(cmd_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.dp_cmd   (dp_cmd),
		.dp_sts   (dp_sts)
	);

	// Table and compare
	cidral_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.dp_cmd(dp_cmd),
		.dp_sts(dp_sts),
		.res   (res)
	);

	// No write into a full table
	`CIDRAL_NEVER(a_no_write_full, dp_cmd.wr_en && dp_sts.full, "table write while full")
	// A result is loaded only when the output register is free
	`CIDRAL_ASSERT(a_load_free, dp_cmd.out_load |-> (!res_valid || !res_stall), "result overwritten")
	// A scan never starts on an empty table
	`CIDRAL_ASSERT(a_scan_nonempty, dp_cmd.scan_start |-> !dp_sts.empty, "scan of empty table")

endmodule
